// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the wipe animator.
// Include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

// ===== hdl/lswa_pkg.sv =====
// Package of the wipe animator: opcodes, command word and result word types.
// No dependencies.
`default_nettype none
package lswa_pkg;
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SWITCH = 2'd1;
	localparam logic [1:0] OP_SET    = 2'd2;

	localparam logic [2:0] REG_PIXELS   = 3'd0;
	localparam logic [2:0] REG_DURATION = 3'd1;
	localparam logic [2:0] REG_GAP      = 3'd2;
	localparam logic [2:0] REG_RED      = 3'd3;
	localparam logic [2:0] REG_GREEN    = 3'd4;
	localparam logic [2:0] REG_BLUE     = 3'd5;

	// Command from the front part to the back part.
	typedef struct packed {
		logic        frame;     // 1: render a frame, 0: emit toggle notice
		logic        light_on;
		logic [16:0] progress;  // Q1.16, 65536 is full
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       light_on;
		logic       last;
	} res_t;
endpackage
`default_nettype wire

// ===== hdl/lswa_divider.sv =====
// Restoring divider, one quotient bit per cycle, quotient floor(num/den).
// No dependencies.
`default_nettype none
module lswa_divider #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] num_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q[DW-1:0], num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign quo   = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/lswa_front.sv =====
// Front part: keeps time, switch and target state, classifies input words
// and computes frame progress with a serial divider. Uses lswa_pkg, lswa_divider.
`default_nettype none
`include "assert_macros.svh"
module lswa_front
	import lswa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic        level,
	input  wire logic [15:0] dur,
	input  wire logic [7:0]  gap,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);
	logic [31:0] now_q, finish_q, last_frame_q;
	logic        target_q, sw_q;
	logic [15:0] d_eff;
	logic [31:0] now_n, rem, rem_sat;
	logic [15:0] len;
	logic        div_start, div_busy, div_done;
	logic [32:0] div_quo;
	logic        tgt_frame_q;
	logic        accept;
	logic [31:0] frem, frem_sat;

	assign d_eff = (dur == 16'd0) ? 16'd1 : dur;
	assign accept = push && !full;
	// Input is held off while a frame's progress is being divided, in the
	// cycle its quotient is handed over, and while a command waits.
	assign full = cmd_valid || div_busy || div_done;
	assign now_n = now_q + 32'd1;

	// Remaining time at the current time, saturated at the duration.
	assign rem = finish_q - now_q;
	assign rem_sat = (rem > {16'd0, d_eff}) ? {16'd0, d_eff} : rem;
	assign len = (now_q <= finish_q) ? (d_eff - rem_sat[15:0]) : d_eff;

	always_comb begin
		div_start = 1'b0;
		if (accept && op == OP_TICK && (now_n - last_frame_q) > {24'd0, gap}
				&& now_n <= finish_q)
			div_start = 1'b1;
	end

	assign frem = finish_q - now_n;
	assign frem_sat = (frem > {16'd0, d_eff}) ? {16'd0, d_eff} : frem;

	lswa_divider #(.NW(33), .DW(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({1'b0, d_eff - frem_sat[15:0], 16'd0}), .den(d_eff),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			finish_q     <= '0;
			last_frame_q <= '0;
			target_q     <= 1'b0;
			sw_q         <= 1'b0;
			cmd_valid    <= 1'b0;
			tgt_frame_q  <= 1'b0;
			cmd          <= '0;
		end else begin
			if (cmd_valid && cmd_ready)
				cmd_valid <= 1'b0;
			if (div_done) begin
				cmd_valid    <= 1'b1;
				cmd.frame    <= 1'b1;
				cmd.light_on <= 1'b0;
				cmd.progress <= tgt_frame_q ? div_quo[16:0] : 17'h10000 - div_quo[16:0];
			end
			if (accept) begin
				unique case (op)
					OP_TICK: begin
						now_q <= now_n;
						if (div_start) begin
							last_frame_q <= now_n;
							tgt_frame_q  <= target_q;
						end
					end
					OP_SWITCH: begin
						if (level != sw_q) begin
							sw_q         <= level;
							target_q     <= !target_q;
							finish_q     <= now_q + {16'd0, len};
							cmd_valid    <= 1'b1;
							cmd.frame    <= 1'b0;
							cmd.light_on <= !target_q;
							cmd.progress <= '0;
						end
					end
					OP_SET: begin
						if (level != target_q) begin
							target_q <= level;
							finish_q <= now_q + {16'd0, len};
						end
					end
					default: ;
				endcase
			end
		end
	end

	`CHK_IMPLY(a_no_start_busy, clk, arst_n, div_busy, !div_start)
	`CHK_NEXT(a_done_gives_cmd, clk, arst_n, div_done, cmd_valid)
endmodule
`default_nettype wire

// ===== hdl/lswa_back.sv =====
// Back part: turns commands into result words, one pixel at a time,
// with a serial divider for the position profile. Uses lswa_pkg, lswa_divider.
`default_nettype none
`include "assert_macros.svh"
module lswa_back
	import lswa_pkg::*;
#(
	parameter int MAX_PIXELS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  cmd_t            cmd,
	input  wire logic [6:0] pixels,
	input  wire logic [7:0] cr,
	input  wire logic [7:0] cg,
	input  wire logic [7:0] cb,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_t            res
);
	localparam int NW = $clog2(MAX_PIXELS + 2);
	localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2,
		S_MUL = 3'd3, S_OUT = 3'd4;
	logic [2:0]    st_q;
	logic [16:0]   prog_q;
	logic [NW-1:0] n_q, i_q, np1;
	logic [NW:0]   m, mm;
	logic          dv_start, dv_busy, dv_done;
	logic [NW+16:0] dv_quo;
	logic [16:0]   a_q;
	logic [33:0]   b_full;
	logic [16:0]   b_q;
	logic [6:0]    n_sat;
	logic [NW+22:0] pn;
	logic signed [NW+23:0] x;
	logic [24:0]   pr_mul, pg_mul, pb_mul;

	assign n_sat = ({25'd0, pixels} > 32'(MAX_PIXELS)) ? 7'(MAX_PIXELS) : pixels;
	assign np1 = n_q + 1'b1;
	assign m  = {i_q, 1'b0} + (NW+1)'(2);
	assign mm = (m > {1'b0, np1}) ? ({np1, 1'b0} - m) : m;
	assign dv_start = (st_q == S_DIV);
	assign cmd_ready = (st_q == S_IDLE) && !res_valid;

	lswa_divider #(.NW(NW+17), .DW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num({mm, 16'd0}), .den(np1),
		.busy(dv_busy), .done(dv_done), .quo(dv_quo)
	);

	assign pn = prog_q * n_q;
	assign x  = $signed({1'b0, pn}) - $signed({1'b0, i_q, 16'd0});
	assign b_full = a_q * dv_quo[16:0];

	// Channel products are kept at full width before the top byte is taken.
	assign pr_mul = b_q * cr;
	assign pg_mul = b_q * cg;
	assign pb_mul = b_q * cb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			res_valid <= 1'b0;
			res       <= '0;
			prog_q    <= '0;
			n_q       <= '0;
			i_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
		end else begin
			if (res_valid && res_ready)
				res_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (cmd_valid && cmd_ready) begin
					if (!cmd.frame) begin
						res_valid       <= 1'b1;
						res.kind        <= 1'b1;
						res.pixel_index <= '0;
						res.red         <= '0;
						res.green       <= '0;
						res.blue        <= '0;
						res.light_on    <= cmd.light_on;
						res.last        <= 1'b1;
					end else if (n_sat != 7'd0) begin
						prog_q <= cmd.progress;
						n_q    <= NW'(n_sat);
						i_q    <= '0;
						st_q   <= S_DIV;
					end
				end
				S_DIV: begin
					st_q <= S_WAIT;
					if (x < 0) a_q <= '0;
					else if (x > 65536) a_q <= 17'h10000;
					else a_q <= x[16:0];
				end
				S_WAIT: if (dv_done) st_q <= S_MUL;
				S_MUL: begin
					b_q  <= b_full[32:16];
					st_q <= S_OUT;
				end
				S_OUT: if (!res_valid) begin
					res_valid       <= 1'b1;
					res.kind        <= 1'b0;
					res.pixel_index <= 6'(i_q);
					res.red         <= pr_mul[23:16];
					res.green       <= pg_mul[23:16];
					res.blue        <= pb_mul[23:16];
					res.light_on    <= 1'b0;
					res.last        <= (np1 - 1'b1 == i_q + 1'b1);
					i_q             <= i_q + 1'b1;
					st_q <= (i_q + 1'b1 == n_q) ? S_IDLE : S_DIV;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPLY(a_idle_div, clk, arst_n, st_q == S_IDLE, !dv_busy)
	`CHK_NEXT(a_div_runs, clk, arst_n, st_q == S_DIV, dv_busy)
endmodule
`default_nettype wire

// ===== hdl/led_strip_wipe_animator.sv =====
// Top level of the light strip wipe animator: registers, front, back.
// Uses lswa_pkg, lswa_front, lswa_back.
//
// Channel   Direction  Handshake         Contents
// input     in         push / full       op, level
// result    out        pop / empty       kind, pixel_index, red..blue, light_on, last
// config    in         APB psel/penable  six registers at byte addresses 4*i
//
// A frame tick has its progress worked out in the front part's divider, then each
// pixel its position profile in the back part's divider; other words use neither.
// One word waits in the front-to-back command register and one in the result
// register. Input is also held off while the progress divider runs, and the back
// part takes no command while it is still rendering a frame.
// Reset is asynchronous and brings registers to their documented values.
`default_nettype none
module led_strip_wipe_animator
	import lswa_pkg::*;
#(
	parameter int MAX_PIXELS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic        level,
	output logic             empty,
	input  wire logic        pop,
	output logic             kind,
	output logic [5:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             light_on,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [6:0]  pixels_q;
	logic [15:0] dur_q;
	logic [7:0]  gap_q, red_q, green_q, blue_q;
	logic        cmd_valid, cmd_ready, res_valid;
	cmd_t        cmd;
	res_t        res;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// Register writes land on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_q <= 7'd64;
			dur_q    <= 16'd5000;
			gap_q    <= 8'd16;
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_PIXELS:   pixels_q <= pwdata[6:0];
				REG_DURATION: dur_q    <= pwdata[15:0];
				REG_GAP:      gap_q    <= pwdata[7:0];
				REG_RED:      red_q    <= pwdata[7:0];
				REG_GREEN:    green_q  <= pwdata[7:0];
				REG_BLUE:     blue_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data of the currently addressed register.
	always_comb begin
		unique case (reg_idx)
			REG_PIXELS:   prdata = {25'd0, pixels_q};
			REG_DURATION: prdata = {16'd0, dur_q};
			REG_GAP:      prdata = {24'd0, gap_q};
			REG_RED:      prdata = {24'd0, red_q};
			REG_GREEN:    prdata = {24'd0, green_q};
			REG_BLUE:     prdata = {24'd0, blue_q};
			default:      prdata = '0;
		endcase
	end

	lswa_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op), .level(level),
		.dur(dur_q), .gap(gap_q), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	lswa_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .pixels(pixels_q), .cr(red_q), .cg(green_q), .cb(blue_q),
		.res_valid(res_valid), .res_ready(pop), .res(res)
	);

	// The result register is the head of the output queue.
	assign empty       = !res_valid;
	assign kind        = res.kind;
	assign pixel_index = res.pixel_index;
	assign red         = res.red;
	assign green       = res.green;
	assign blue        = res.blue;
	assign light_on    = res.light_on;
	assign last        = res.last;
endmodule
`default_nettype wire

// ===== tb/tb_led_strip_wipe_animator.sv =====
// Testbench of the light strip wipe animator: random and directed input words,
// a scoreboard that predicts every result word, and APB register writes.
// Depends on lswa_pkg and led_strip_wipe_animator.
`timescale 1ns / 100ps
`default_nettype none

// Holds a copy of the animator state and configuration, works out the result
// words that each accepted input word causes, and checks results in order.
class wipe_scoreboard;
	logic [6:0]  pixel_count;
	logic [15:0] anim_duration;
	logic [7:0]  frame_gap;
	logic [7:0]  colour_red, colour_green, colour_blue;
	logic [31:0] now_ms, finish_time, last_frame_time;
	logic        target_on, last_switch_level;
	lswa_pkg::res_t pending_words[$];
	int failures;

	function new();
		pixel_count = 64;
		anim_duration = 5000;
		frame_gap = 16;
		colour_red = 0;
		colour_green = 0;
		colour_blue = 0;
		now_ms = 0;
		finish_time = 0;
		last_frame_time = 0;
		target_on = 0;
		last_switch_level = 0;
		failures = 0;
	endfunction

	function void write_register(logic [2:0] index, logic [31:0] value);
		case (index)
			lswa_pkg::REG_PIXELS:   pixel_count = value[6:0];
			lswa_pkg::REG_DURATION: anim_duration = value[15:0];
			lswa_pkg::REG_GAP:      frame_gap = value[7:0];
			lswa_pkg::REG_RED:      colour_red = value[7:0];
			lswa_pkg::REG_GREEN:    colour_green = value[7:0];
			lswa_pkg::REG_BLUE:     colour_blue = value[7:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] duration();
		return (anim_duration == 0) ? 32'd1 : {16'd0, anim_duration};
	endfunction

	// A new animation is shortened by whatever the running one has left.
	function void start_animation(logic want);
		logic [31:0] dur, len, rem;
		dur = duration();
		len = dur;
		if (now_ms <= finish_time) begin
			rem = finish_time - now_ms;
			if (rem > dur)
				rem = dur;
			len = dur - rem;
		end
		finish_time = now_ms + len;
		target_on = want;
	endfunction

	function void predict_frame();
		logic [31:0] dur, rem;
		longint unsigned p, m, pb, a, b, n;
		longint x;
		lswa_pkg::res_t w;
		dur = duration();
		rem = finish_time - now_ms;
		if (rem > dur)
			rem = dur;
		p = ({32'd0, dur - rem} << 16) / dur;
		if (!target_on)
			p = 65536 - p;
		n = (pixel_count > 64) ? 64 : pixel_count;
		for (int i = 0; i < n; i++) begin
			x = longint'(p * n) - (longint'(i) << 16);
			if (x < 0)
				x = 0;
			if (x > 65536)
				x = 65536;
			a = x;
			m = 2 * (i + 1);
			if (m > n + 1)
				m = 2 * (n + 1) - m;
			pb = (m << 16) / (n + 1);
			b = (a * pb) >> 16;
			w = '0;
			w.pixel_index = i[5:0];
			w.red = 8'((b * colour_red) >> 16);
			w.green = 8'((b * colour_green) >> 16);
			w.blue = 8'((b * colour_blue) >> 16);
			w.last = (i + 1 == n);
			pending_words.push_back(w);
		end
	endfunction

	function void note_word(logic [1:0] op, logic level);
		lswa_pkg::res_t w;
		case (op)
			lswa_pkg::OP_TICK: begin
				now_ms = now_ms + 1;
				if (now_ms - last_frame_time > frame_gap && now_ms <= finish_time) begin
					last_frame_time = now_ms;
					predict_frame();
				end
			end
			lswa_pkg::OP_SWITCH: begin
				if (level != last_switch_level) begin
					last_switch_level = level;
					start_animation(!target_on);
					w = '0;
					w.kind = 1'b1;
					w.light_on = target_on;
					w.last = 1'b1;
					pending_words.push_back(w);
				end
			end
			lswa_pkg::OP_SET: begin
				if (level != target_on)
					start_animation(level);
			end
			default: ;
		endcase
	endfunction

	function void compare(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endfunction

	function void check_word(lswa_pkg::res_t got);
		lswa_pkg::res_t want;
		if (pending_words.size() == 0) begin
			$error("result word with nothing expected: %p", got);
			failures++;
			return;
		end
		want = pending_words.pop_front();
		compare("kind", want.kind, got.kind);
		compare("pixel_index", want.pixel_index, got.pixel_index);
		compare("red", want.red, got.red);
		compare("green", want.green, got.green);
		compare("blue", want.blue, got.blue);
		compare("light_on", want.light_on, got.light_on);
		compare("last", want.last, got.last);
	endfunction
endclass

module tb_led_strip_wipe_animator;
	import lswa_pkg::*;

	// Cycles with no handshake on any port before the run is declared hung.
	// Each word of a full 64 pixel frame may wait out a long pop stall,
	// so this limit leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 20000;
	// Quiet cycles after the last expected word, so that a frame with no
	// pixels still finishing inside the block is over before anything else.
	localparam int SETTLE_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  op = OP_TICK;
	logic        level = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        kind;
	logic [5:0]  pixel_index;
	logic [7:0]  red, green, blue;
	logic        light_on, last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	wipe_scoreboard frame_sb = new();
	int idle_cycles = 0;
	int pop_stall = 0;

	always #6 clk = ~clk;

	led_strip_wipe_animator dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .op(op), .level(level),
		.empty(empty), .pop(pop),
		.kind(kind), .pixel_index(pixel_index),
		.red(red), .green(green), .blue(blue),
		.light_on(light_on), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiving side. The word on the result ports is sampled at the
	// edge, before the block moves on, so the check sees exactly the word
	// that was taken. Stalls come in runs of random length.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			frame_sb.check_word('{kind, pixel_index, red, green, blue, light_on, last});
		if (pop_stall > 0) begin
			pop_stall <= pop_stall - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				pop_stall <= pick_gap();
		end
	end

	// Any handshake counts as progress; a long stretch without one is a hang.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle since pready is always high.
	task automatic write_register(logic [2:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		frame_sb.write_register(index, value);
	endtask

	task automatic configure(int pixels, int dur, int gap, int r, int g, int b);
		write_register(REG_PIXELS, pixels);
		write_register(REG_DURATION, dur);
		write_register(REG_GAP, gap);
		write_register(REG_RED, r);
		write_register(REG_GREEN, g);
		write_register(REG_BLUE, b);
	endtask

	// Offers one word and holds it until the block takes it. Push stays high
	// into the next word unless a gap is drawn, so back-to-back words occur.
	task automatic send_word(logic [1:0] word_op, logic word_level);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= word_op;
		level <= word_level;
		do @(posedge clk); while (full);
		frame_sb.note_word(word_op, word_level);
	endtask

	// Ticks dominate, as on a real strip; switch and set words steer the
	// animation back and forth, and the unused opcode is mixed in now and then.
	task automatic send_random(int count);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send_word(OP_TICK, $urandom_range(0, 1));
			else if (r < 78)
				send_word(OP_SWITCH, $urandom_range(0, 1));
			else if (r < 92)
				send_word(OP_SET, $urandom_range(0, 1));
			else
				send_word(2'd3, $urandom_range(0, 1));
		end
	endtask

	// The sender stops until every expected word has come back, then lets
	// the block settle so that a register write finds it idle.
	task automatic drain();
		push <= 1'b0;
		while (frame_sb.pending_words.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a short strip and a short animation: ignored
		// opcodes, unchanged commands and switch levels, toggles that
		// reverse a running wipe, and an explicit on and off.
		configure(4, 30, 0, 255, 128, 1);
		send_word(2'd3, 1'b0);
		send_word(2'd3, 1'b1);
		send_word(OP_SET, 1'b0);
		send_word(OP_SWITCH, 1'b0);
		send_word(OP_TICK, 1'b0);
		send_word(OP_SET, 1'b1);
		repeat (3) send_word(OP_TICK, 1'b0);
		send_word(OP_SWITCH, 1'b1);
		repeat (3) send_word(OP_TICK, 1'b0);
		send_word(OP_SWITCH, 1'b0);
		repeat (2) send_word(OP_TICK, 1'b1);
		send_word(OP_SET, 1'b0);
		send_word(OP_SET, 1'b0);
		repeat (2) send_word(OP_TICK, 1'b0);
		send_word(OP_SET, 1'b1);
		repeat (4) send_word(OP_TICK, 1'b0);
		drain();

		// Full strip, longest animation and widest frame gap.
		configure(64, 65535, 255, 255, 255, 255);
		send_random(20);
		drain();

		// No pixels and a zero duration, which acts as one tick.
		configure(0, 0, 0, 17, 34, 51);
		send_random(25);
		drain();

		// Pixel count beyond the strip size, shortest animation, black.
		configure(127, 1, 1, 0, 0, 0);
		send_random(25);
		drain();

		// A single pixel with random colours.
		configure(1, 100, 3, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		send_random(30);
		drain();

		// Several random small settings for the rest of the run.
		for (int ph = 0; ph < 3; ph++) begin
			configure($urandom_range(1, 8), $urandom_range(1, 60), $urandom_range(0, 4),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			send_random(20);
			drain();
		end

		if (frame_sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

`default_nettype wire
